// ===== hw/rtl/lsm_pkg.sv =====
// ----------------------------------------------------------------------------
// lsm_pkg
// Shared types, constants and helpers of the line substring matcher.
// ----------------------------------------------------------------------------
package lsm_pkg;

    localparam int LSM_MAX_PATTERN = 32;   // cells in the chain by default
    localparam int LSM_PAT_CHARS   = 32;   // characters the pattern words hold
    localparam int LSM_PAT_IDX_W   = 5;    // index into the pattern characters
    localparam int LSM_NUM_WORDS   = 4;
    localparam int LSM_WORD_W      = 64;
    localparam int LSM_LEN_W       = 6;
    localparam int LSM_CHAR_W      = 8;
    localparam int LSM_ADDR_W      = 6;
    localparam int LSM_REG_IDX_W   = 3;

    typedef enum logic [LSM_REG_IDX_W-1:0] {
        REG_CASE_SENSITIVE = 3'd0,
        REG_PATTERN_LENGTH = 3'd1,
        REG_PATTERN_WORD_0 = 3'd2,
        REG_PATTERN_WORD_1 = 3'd3,
        REG_PATTERN_WORD_2 = 3'd4,
        REG_PATTERN_WORD_3 = 3'd5
    } lsm_reg_idx_t;

    typedef struct packed {
        logic                                     case_sensitive;
        logic [LSM_LEN_W-1:0]                     pattern_length;
        logic [LSM_NUM_WORDS-1:0][LSM_WORD_W-1:0] pattern_word;
    } lsm_cfg_t;

    // Folds an ASCII upper-case letter to lower case when folding is on.
    function automatic logic [LSM_CHAR_W-1:0] lsm_fold(
        input logic [LSM_CHAR_W-1:0] c,
        input logic                  fold_en
    );
        logic [LSM_CHAR_W-1:0] r;
        r = c;
        if (fold_en && (c >= 8'h41) && (c <= 8'h5A))
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/lsm_regs.sv =====
// ----------------------------------------------------------------------------
// lsm_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module lsm_regs
    import lsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [LSM_ADDR_W-1:0] paddr,
    input  logic [LSM_WORD_W-1:0] pwdata,
    output logic [LSM_WORD_W-1:0] prdata,
    output logic                  pready,
    output lsm_cfg_t              cfg
);

    lsm_cfg_t                 cfg_reg;
    lsm_cfg_t                 cfg_next;
    logic [LSM_REG_IDX_W-1:0] reg_idx;
    logic                     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[LSM_ADDR_W-1:LSM_ADDR_W-LSM_REG_IDX_W];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_CASE_SENSITIVE: cfg_next.case_sensitive  = pwdata[0];
                REG_PATTERN_LENGTH: cfg_next.pattern_length  = pwdata[LSM_LEN_W-1:0];
                REG_PATTERN_WORD_0: cfg_next.pattern_word[0] = pwdata;
                REG_PATTERN_WORD_1: cfg_next.pattern_word[1] = pwdata;
                REG_PATTERN_WORD_2: cfg_next.pattern_word[2] = pwdata;
                REG_PATTERN_WORD_3: cfg_next.pattern_word[3] = pwdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.case_sensitive <= 1'b1;
            cfg_reg.pattern_length <= LSM_LEN_W'(1);
            cfg_reg.pattern_word   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CASE_SENSITIVE: prdata = {{(LSM_WORD_W-1){1'b0}}, cfg_reg.case_sensitive};
            REG_PATTERN_LENGTH: prdata = {{(LSM_WORD_W-LSM_LEN_W){1'b0}},
                                          cfg_reg.pattern_length};
            REG_PATTERN_WORD_0: prdata = cfg_reg.pattern_word[0];
            REG_PATTERN_WORD_1: prdata = cfg_reg.pattern_word[1];
            REG_PATTERN_WORD_2: prdata = cfg_reg.pattern_word[2];
            REG_PATTERN_WORD_3: prdata = cfg_reg.pattern_word[3];
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/lsm_cell.sv =====
// ----------------------------------------------------------------------------
// lsm_cell
// One history position: holds a character of the line and compares the
// character arriving at it with its pattern character.
// ----------------------------------------------------------------------------
module lsm_cell
    import lsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  shift_en,
    input  logic                  clear,
    input  logic                  fold_en,
    input  logic [LSM_CHAR_W-1:0] in_char,
    input  logic                  in_valid,
    input  logic                  care,
    input  logic [LSM_CHAR_W-1:0] pat_char,
    output logic [LSM_CHAR_W-1:0] out_char,
    output logic                  out_valid,
    output logic                  hit
);

    logic [LSM_CHAR_W-1:0] char_reg;
    logic [LSM_CHAR_W-1:0] char_next;
    logic                  valid_reg;
    logic                  valid_next;

    // The comparison sees the character that this beat moves into the cell.
    assign hit = !care ||
                 (in_valid && (lsm_fold(in_char, fold_en) == lsm_fold(pat_char, fold_en)));

    always_comb
    begin
        char_next  = char_reg;
        valid_next = valid_reg;
        if (shift_en)
        begin
            char_next  = in_char;
            valid_next = in_valid && !clear;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign out_char  = char_reg;
    assign out_valid = valid_reg;

endmodule

// ===== hw/rtl/line_substring_matcher.sv =====
// ----------------------------------------------------------------------------
// line_substring_matcher
// Grep-style line filter with optional ASCII case folding.
// ----------------------------------------------------------------------------
// Text enters one character per beat on the slave stream, tlast marking the
// last character of a line; the block takes one character every clock cycle
// while no held verdict stands untaken. The line history sits in a chain of
// MAX_PATTERN cells that shifts on every accepted beat, and all cells compare
// against their pattern characters in the same cycle, so the rate is set by
// that combinational compare across the chain. The verdict for a line appears
// on the master stream in the cycle after its last character is accepted, in
// bit 0 of tdata. The text stream stalls in every cycle in which a held
// verdict is not taken, whether or not the waiting character ends a line.
// ----------------------------------------------------------------------------
module line_substring_matcher
    import lsm_pkg::*;
#(
    parameter int MAX_PATTERN = LSM_MAX_PATTERN
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB-style configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [LSM_ADDR_W-1:0] paddr,
    input  logic [LSM_WORD_W-1:0] pwdata,
    output logic [LSM_WORD_W-1:0] prdata,
    output logic                  pready,
    // Text stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] text_char
    input  logic                  s_tlast,   // line_end
    // Verdict stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata    // [0] line_matched, [7:1] zero
);

    lsm_cfg_t             cfg;
    logic [LSM_LEN_W-1:0] len_eff;
    logic                 accept;
    logic                 line_done;
    logic                 match_now;

    logic [LSM_PAT_CHARS-1:0][LSM_CHAR_W-1:0] pat_bytes;
    logic [MAX_PATTERN-1:0][LSM_CHAR_W-1:0]   cell_char;
    logic [MAX_PATTERN-1:0]                   cell_valid;
    logic [MAX_PATTERN-1:0]                   cell_hit;

    logic found_reg;
    logic found_next;
    logic m_valid_reg;
    logic m_valid_next;
    logic m_match_reg;
    logic m_match_next;

    lsm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign pat_bytes = cfg.pattern_word;
    assign len_eff   = (cfg.pattern_length > LSM_LEN_W'(MAX_PATTERN)) ?
                       LSM_LEN_W'(MAX_PATTERN) : cfg.pattern_length;

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign line_done = accept && s_tlast;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            logic                     care;
            logic [LSM_LEN_W-1:0]     pat_pos;
            logic [LSM_CHAR_W-1:0]    in_char;
            logic                     in_valid;

            // Cell k holds the character k places back, which lines up with
            // pattern character len-1-k.
            assign care    = LSM_LEN_W'(k) < len_eff;
            assign pat_pos = len_eff - LSM_LEN_W'(1) - LSM_LEN_W'(k);

            if (k == 0)
            begin : g_head
                assign in_char  = s_tdata;
                assign in_valid = 1'b1;
            end
            else
            begin : g_body
                assign in_char  = cell_char[k-1];
                assign in_valid = cell_valid[k-1];
            end

            lsm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (accept),
                .clear     (s_tlast),
                .fold_en   (!cfg.case_sensitive),
                .in_char   (in_char),
                .in_valid  (in_valid),
                .care      (care),
                .pat_char  (pat_bytes[pat_pos[LSM_PAT_IDX_W-1:0]]),
                .out_char  (cell_char[k]),
                .out_valid (cell_valid[k]),
                .hit       (cell_hit[k])
            );
        end
    endgenerate

    assign match_now = &cell_hit;

    always_comb
    begin
        found_next   = found_reg;
        m_valid_next = m_valid_reg;
        m_match_next = m_match_reg;
        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (accept)
        begin
            found_next = (found_reg || match_now) && !s_tlast;
        end
        if (line_done)
        begin
            m_valid_next = 1'b1;
            m_match_next = found_reg || match_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_match_reg <= m_match_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_match_reg};

    // A line end always produces a verdict in the next cycle.
    a_verdict_follows: assert property (
        @(posedge clk) disable iff (!rst_n)
        line_done |=> m_tvalid
    ) else $error("line end did not produce a verdict");

    // A held verdict that is not taken blocks the text stream.
    a_no_overrun: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready
    ) else $error("input accepted while verdict stalled");

    // The history and the found flag are empty after a line end.
    a_line_cleared: assert property (
        @(posedge clk) disable iff (!rst_n)
        line_done |=> ((cell_valid == '0) && !found_reg)
    ) else $error("line state not cleared at line end");

    // An empty pattern matches every line.
    a_empty_pattern: assert property (
        @(posedge clk) disable iff (!rst_n)
        (line_done && (len_eff == '0)) |=> m_tdata[0]
    ) else $error("empty pattern did not match");

endmodule
